// ===== rtl/core/pwmu_pkg.sv =====
// pwmu_pkg: shared types and constants for the priority wakeup mutex unit
// holds field widths, status and op codes, controller/datapath command structs
// no dependencies
package pwmu_pkg;

  localparam int PID_W   = 8;
  localparam int PRIO_W  = 4;
  localparam int RES_W   = 2;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = PID_W + PRIO_W;

  // seed for the minimum search, above every legal priority
  localparam logic [PRIO_W:0] PRIO_SEED = {1'b1, {PRIO_W{1'b0}}};

  typedef enum logic {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_FREED    = 3'd3,
    ST_HANDOVER = 3'd4,
    ST_REJECTED = 3'd5
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    grant;
    logic    enqueue;
    logic    rel_free;
    logic    scan_start;
    logic    scan_rd;
    logic    scan_cmp;
    logic    shift_rd;
    logic    shift_wr;
    logic    handover;
    logic    load_out;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic op_signal;
    logic is_free;
    logic owner_match;
    logic cnt_zero;
    logic cnt_full;
    logic more;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/pwmu_dp.sv =====
// pwmu_dp: datapath of the mutex unit, per-resource lock state, wait queue memory,
// minimum-priority scan, queue compaction and result register
// depends on pwmu_pkg
module pwmu_dp #(
  parameter int QUEUE_DEPTH   = 4,
  parameter int NUM_RESOURCES = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_op,
  input  logic [pwmu_pkg::RES_W-1:0]     in_resource,
  input  logic [pwmu_pkg::PID_W-1:0]     in_pid,
  input  logic [pwmu_pkg::PRIO_W-1:0]    in_prio,
  input  pwmu_pkg::dp_cmd_t              cmd,
  output pwmu_pkg::dp_sts_t              sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [pwmu_pkg::STAT_W-1:0]    out_status,
  output logic [pwmu_pkg::PID_W-1:0]     out_next_owner,
  output logic                           out_next_owner_valid
);
  import pwmu_pkg::*;

  localparam int TOTAL = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

  // captured request
  logic              op_r;
  logic [RES_W-1:0]  res_r;
  logic [PID_W-1:0]  pid_r;
  logic [PRIO_W-1:0] prio_r;

  // per-resource lock state
  logic              free_r   [NUM_RESOURCES];
  logic              free_nxt [NUM_RESOURCES];
  logic [PID_W-1:0]  owner_r  [NUM_RESOURCES];
  logic [PID_W-1:0]  owner_nxt[NUM_RESOURCES];
  logic [CW-1:0]     count_r  [NUM_RESOURCES];
  logic [CW-1:0]     count_nxt[NUM_RESOURCES];

  // scan and compaction
  logic [IW-1:0]     idx_r;
  logic [IW-1:0]     best_idx_r;
  logic [PRIO_W:0]   best_prio_r;
  logic [PID_W-1:0]  best_pid_r;

  logic [ENTRY_W-1:0] mem [TOTAL];
  logic [ENTRY_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  status_t           out_status_r;
  logic [PID_W-1:0]  out_owner_r;
  logic              out_ov_r;

  logic [RW-1:0]      res_idx;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx_ext;
  logic [CW:0]        idx_inc;
  logic               more;
  logic               better;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] wr_data;

  function automatic logic [AW-1:0] slot_addr(input logic [RW-1:0] r, input logic [CW-1:0] s);
    slot_addr = AW'(32'(r) * QUEUE_DEPTH + 32'(s));
  endfunction

  assign res_idx = RW'(res_r);
  assign cnt     = count_r[res_idx];
  assign idx_ext = CW'(idx_r);
  assign idx_inc = {1'b0, idx_ext} + 1'b1;
  assign more    = idx_inc < {1'b0, cnt};
  assign better  = {1'b0, rd_data_r[PRIO_W-1:0]} < best_prio_r;

  assign sts.in_range    = 32'(res_r) < NUM_RESOURCES;
  assign sts.op_signal   = (op_t'(op_r) == OP_SIGNAL);
  assign sts.is_free     = free_r[res_idx];
  assign sts.owner_match = (owner_r[res_idx] == pid_r);
  assign sts.cnt_zero    = (cnt == '0);
  assign sts.cnt_full    = (32'(cnt) >= QUEUE_DEPTH);
  assign sts.more        = more;
  assign sts.out_busy    = out_valid_r & out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      res_r  <= in_resource;
      pid_r  <= in_pid;
      prio_r <= in_prio;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_RESOURCES; i++) begin
      free_nxt[i]  = free_r[i];
      owner_nxt[i] = owner_r[i];
      count_nxt[i] = count_r[i];
    end
    if (cmd.grant) begin
      free_nxt[res_idx]  = 1'b0;
      owner_nxt[res_idx] = pid_r;
    end
    if (cmd.enqueue) begin
      count_nxt[res_idx] = cnt + 1'b1;
    end
    if (cmd.rel_free) begin
      free_nxt[res_idx]  = 1'b1;
      owner_nxt[res_idx] = '0;
    end
    if (cmd.handover) begin
      count_nxt[res_idx] = cnt - 1'b1;
      owner_nxt[res_idx] = best_pid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_r[i]  <= 1'b1;
        owner_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        free_r[i]  <= free_nxt[i];
        owner_r[i] <= owner_nxt[i];
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // scan for the smallest priority, strict compare keeps the oldest
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r       <= '0;
      best_idx_r  <= '0;
      best_prio_r <= PRIO_SEED;
    end else if (cmd.scan_cmp) begin
      if (better) begin
        best_idx_r  <= idx_r;
        best_prio_r <= {1'b0, rd_data_r[PRIO_W-1:0]};
        best_pid_r  <= rd_data_r[ENTRY_W-1:PRIO_W];
      end
      if (more) begin
        idx_r <= idx_inc[IW-1:0];
      end else if (better) begin
        idx_r <= idx_r;
      end else begin
        idx_r <= best_idx_r;
      end
    end else if (cmd.shift_wr) begin
      idx_r <= idx_inc[IW-1:0];
    end
  end

  assign mem_we  = cmd.enqueue | cmd.shift_wr;
  assign mem_re  = cmd.scan_rd | (cmd.shift_rd & more);
  assign wr_addr = cmd.enqueue ? slot_addr(res_idx, cnt) : slot_addr(res_idx, idx_ext);
  assign rd_addr = cmd.scan_rd ? slot_addr(res_idx, idx_ext)
                               : slot_addr(res_idx, idx_inc[CW-1:0]);
  assign wr_data = cmd.enqueue ? {pid_r, prio_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      out_owner_r  <= (cmd.status == ST_HANDOVER) ? best_pid_r : '0;
      out_ov_r     <= (cmd.status == ST_HANDOVER);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_next_owner       = out_owner_r;
  assign out_next_owner_valid = out_ov_r;

endmodule

// ===== rtl/core/pwmu_ctrl.sv =====
// pwmu_ctrl: controller state machine of the mutex unit
// sequences decision, queue scan, compaction and result load
// depends on pwmu_pkg
module pwmu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pwmu_pkg::dp_sts_t sts,
  output pwmu_pkg::dp_cmd_t cmd
);
  import pwmu_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECIDE   = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CMP = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_FIN      = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t status_r;
  status_t status_nxt;

  always_comb begin
    cmd        = '0;
    cmd.status = status_r;
    state_nxt  = state_r;
    status_nxt = status_r;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESULT;
        if (!sts.in_range) begin
          status_nxt = ST_REJECTED;
        end else if (!sts.op_signal) begin
          if (sts.is_free) begin
            cmd.grant  = 1'b1;
            status_nxt = ST_GRANTED;
          end else if (sts.cnt_full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            cmd.enqueue = 1'b1;
            status_nxt  = ST_BLOCKED;
          end
        end else if (sts.is_free || !sts.owner_match) begin
          status_nxt = ST_REJECTED;
        end else if (sts.cnt_zero) begin
          cmd.rel_free = 1'b1;
          status_nxt   = ST_FREED;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = sts.more ? S_SCAN_RD : S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = sts.more ? S_SHIFT_WR : S_FIN;
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_FIN: begin
        cmd.handover = 1'b1;
        status_nxt   = ST_HANDOVER;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

endmodule

// ===== rtl/core/priority_wakeup_mutex_unit.sv =====
// priority_wakeup_mutex_unit: lock unit with a priority wait queue per resource
// a request is captured, decided, then its result is loaded in the result state; a handover
// also scans every queued waiter for the smallest priority, moves the later waiters up and
// hands the lock over, reading the wait queue memory once per scan and move step
// a new request is taken only in idle, after the last result is loaded; out_stall holds the result state
// reset: synchronous active-low, all resources free, no owners, queues empty
module priority_wakeup_mutex_unit #(
  parameter int QUEUE_DEPTH   = 4,
  parameter int NUM_RESOURCES = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [pwmu_pkg::RES_W-1:0]  in_resource,
  input  logic [pwmu_pkg::PID_W-1:0]  in_pid,
  input  logic [pwmu_pkg::PRIO_W-1:0] in_prio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pwmu_pkg::STAT_W-1:0] out_status,
  output logic [pwmu_pkg::PID_W-1:0]  out_next_owner,
  output logic                        out_next_owner_valid
);
  import pwmu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pwmu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwmu_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .NUM_RESOURCES (NUM_RESOURCES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_op                (in_op),
    .in_resource          (in_resource),
    .in_pid               (in_pid),
    .in_prio              (in_prio),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_next_owner       (out_next_owner),
    .out_next_owner_valid (out_next_owner_valid)
  );

endmodule
